// ===== rtl/core/hlt_pkg.sv =====
// Shared types and constants of the held lock tracker.
package hlt_pkg;

  localparam int CPUS_DEF   = 8;
  localparam int DEPTH_DEF  = 32;
  localparam int ADDR_W     = 64;
  localparam int CPU_W      = 3;
  localparam int CNT_OUT_W  = 6;
  // wide enough for any count up to the largest list depth
  localparam int CNT_MAX_W  = 9;

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CPU_W-1:0]     cpu_t;
  typedef logic [CNT_OUT_W-1:0] cnt_out_t;
  typedef logic [CNT_MAX_W-1:0] cnt_t;

  typedef enum logic [0:0] {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_DONE
  } state_e;

  // broadcast to every cell for the duration of one sweep
  typedef struct packed {
    cmd_e  cmd;
    addr_t addr;
    cnt_t  count;
  } sweep_ctl_t;

  // handed from one cell to the next
  typedef struct packed {
    logic tok;
    logic hit;
  } link_t;

endpackage

// ===== rtl/core/hlt_if.sv =====
// Request and response channel interfaces of the held lock tracker.
interface hlt_req_if;
  logic                valid;
  logic                ready;
  hlt_pkg::cmd_e       cmd;
  hlt_pkg::cpu_t       cpu;
  hlt_pkg::addr_t      lock_address;

  modport source (output valid, output cmd, output cpu, output lock_address, input ready);
  modport sink   (input valid, input cmd, input cpu, input lock_address, output ready);
endinterface

interface hlt_rsp_if;
  logic                valid;
  logic                ready;
  logic                reacquire_warning;
  logic                recorded;
  logic                removed;
  hlt_pkg::cnt_out_t   held_count;

  modport source (output valid, output reacquire_warning, output recorded, output removed,
                  output held_count, input ready);
  modport sink   (input valid, input reacquire_warning, input recorded, input removed,
                  input held_count, output ready);
endinterface

// ===== rtl/core/held_lock_tracker.sv =====
// Top level of the held lock tracker: control, count store and the row of cells.
//
// Keeps, per CPU, an ordered list of up to DEPTH held lock addresses.
// Request channel (req): cmd (acquire or release), cpu and lock_address.
// Response channel (rsp): reacquire_warning, recorded, removed and the
// CPU's held_count after the operation; exactly one response per request.
// One request is handled at a time. After a transfer the slot row and the
// count store are read, a token then walks the row of DEPTH cells, one
// cell per cycle, comparing the address, shifting entries down on a
// release and appending on an acquire, and then leaves the row; the count
// is then written and the response register loaded. A new request is
// taken only once the previous one has left ST_DONE.
// A CPU number of CPUS or more skips the token walk and responds with all zero.
// Reset clears all counts at once (per-CPU valid bits) and empties the
// response register; no clearing pass is needed.
// While rsp is stalled the next request is still taken and worked on; it
// waits in its final cycle until the response register frees up.
module held_lock_tracker #(
  parameter int CPUS  = hlt_pkg::CPUS_DEF,
  parameter int DEPTH = hlt_pkg::DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  hlt_req_if.sink   req,
  hlt_rsp_if.source rsp
);

  localparam int CPU_AW = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int CW     = $clog2(DEPTH + 1);

  typedef logic [CPU_AW-1:0] cpu_idx_t;
  typedef logic [CW-1:0]     count_t;

  hlt_pkg::state_e state, state_next;

  hlt_pkg::cmd_e   cmd_q;
  hlt_pkg::addr_t  addr_q;
  cpu_idx_t        cpu_q;
  logic            skip_q;
  count_t          count_q, count_next;
  logic            start, start_next;
  logic            hit_q;
  logic [CPUS-1:0] cpu_valid;

  logic            accept;
  logic            in_range;
  logic            finish;
  logic            count_we;
  count_t          count_new;
  count_t          count_rdata;
  cpu_idx_t        req_idx;

  hlt_pkg::sweep_ctl_t ctl;
  hlt_pkg::link_t      links [DEPTH+1];
  hlt_pkg::addr_t      slot_data [DEPTH+1];

  assign req.ready = (state == hlt_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_range  = int'(req.cpu) < CPUS;
  assign req_idx   = cpu_idx_t'(req.cpu);

  assign ctl.cmd   = cmd_q;
  assign ctl.addr  = addr_q;
  assign ctl.count = hlt_pkg::cnt_t'(count_q);

  assign links[0].tok    = start;
  assign links[0].hit    = 1'b0;
  assign slot_data[DEPTH] = addr_q;

  always_comb begin
    state_next = state;
    count_next = count_q;
    start_next = 1'b0;
    finish     = 1'b0;
    unique case (state)
      hlt_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = in_range ? hlt_pkg::ST_READ : hlt_pkg::ST_DONE;
        end
      end
      hlt_pkg::ST_READ: begin
        count_next = cpu_valid[cpu_q] ? count_rdata : '0;
        start_next = 1'b1;
        state_next = hlt_pkg::ST_SWEEP;
      end
      hlt_pkg::ST_SWEEP: begin
        if (links[DEPTH].tok) begin
          state_next = hlt_pkg::ST_DONE;
        end
      end
      hlt_pkg::ST_DONE: begin
        // hold until the response register is free
        if (!rsp.valid || rsp.ready) begin
          finish     = 1'b1;
          state_next = hlt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hlt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    count_new = count_q;
    unique case (cmd_q)
      hlt_pkg::CMD_ACQUIRE: begin
        if (count_q < count_t'(DEPTH)) begin
          count_new = count_q + count_t'(1);
        end
      end
      hlt_pkg::CMD_RELEASE: begin
        if (hit_q) begin
          count_new = count_q - count_t'(1);
        end
      end
      default: begin
        count_new = count_q;
      end
    endcase
  end

  assign count_we = finish && !skip_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hlt_pkg::ST_IDLE;
      start     <= 1'b0;
      cpu_valid <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      start <= start_next;
      if (count_we) begin
        cpu_valid[cpu_q] <= 1'b1;
      end
      if (finish) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= req.cmd;
      addr_q <= req.lock_address;
      cpu_q  <= req_idx;
      skip_q <= !in_range;
    end
    count_q <= count_next;
    if (state == hlt_pkg::ST_SWEEP && links[DEPTH].tok) begin
      hit_q <= links[DEPTH].hit;
    end
    if (finish) begin
      if (skip_q) begin
        rsp.reacquire_warning <= 1'b0;
        rsp.recorded          <= 1'b0;
        rsp.removed           <= 1'b0;
        rsp.held_count        <= '0;
      end else begin
        rsp.reacquire_warning <= (cmd_q == hlt_pkg::CMD_ACQUIRE) && hit_q;
        rsp.recorded          <= (cmd_q == hlt_pkg::CMD_ACQUIRE) &&
                                 (count_q < count_t'(DEPTH));
        rsp.removed           <= (cmd_q == hlt_pkg::CMD_RELEASE) && hit_q;
        rsp.held_count        <= hlt_pkg::cnt_out_t'(count_new);
      end
    end
  end

  hlt_ram #(
    .WIDTH (CW),
    .WORDS (CPUS)
  ) u_count_ram (
    .clk   (clk),
    .we    (count_we),
    .waddr (cpu_q),
    .wdata (count_new),
    .re    (accept),
    .raddr (req_idx),
    .rdata (count_rdata)
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    hlt_cell #(
      .CPUS  (CPUS),
      .INDEX (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .cpu_idx  (cpu_q),
      .rd_en    (accept),
      .rd_addr  (req_idx),
      .link_in  (links[k]),
      .nbr_data (slot_data[k+1]),
      .link_out (links[k+1]),
      .data     (slot_data[k])
    );
  end

endmodule

// ===== rtl/core/hlt_ram.sv =====
// Generic single write port RAM with registered read.
module hlt_ram #(
  parameter int WIDTH = 64,
  parameter int WORDS = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/hlt_cell.sv =====
// One list slot for every CPU: compare, shift-down and append as the token passes.
module hlt_cell #(
  parameter int CPUS  = hlt_pkg::CPUS_DEF,
  parameter int INDEX = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  hlt_pkg::sweep_ctl_t                  ctl,
  input  logic [((CPUS > 1) ? $clog2(CPUS) : 1)-1:0] cpu_idx,
  input  logic                                 rd_en,
  input  logic [((CPUS > 1) ? $clog2(CPUS) : 1)-1:0] rd_addr,
  input  hlt_pkg::link_t                       link_in,
  input  hlt_pkg::addr_t                       nbr_data,
  output hlt_pkg::link_t                       link_out,
  output hlt_pkg::addr_t                       data
);

  localparam hlt_pkg::cnt_t SLOT = hlt_pkg::cnt_t'(INDEX);

  logic           occupied;
  logic           here;
  logic           hit;
  logic           we;
  hlt_pkg::addr_t wdata;

  always_comb begin
    occupied = SLOT < ctl.count;
    here     = link_in.tok && occupied && (data == ctl.addr);
    hit      = link_in.hit || here;
    we       = 1'b0;
    wdata    = ctl.addr;
    if (link_in.tok) begin
      unique case (ctl.cmd)
        hlt_pkg::CMD_ACQUIRE: begin
          // append into the first free slot
          we    = (SLOT == ctl.count);
          wdata = ctl.addr;
        end
        hlt_pkg::CMD_RELEASE: begin
          // pull the upper neighbor down once the match is at or below
          we    = hit && occupied;
          wdata = nbr_data;
        end
        default: begin
          we    = 1'b0;
          wdata = ctl.addr;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out <= '0;
    end else begin
      link_out.tok <= link_in.tok;
      link_out.hit <= hit;
    end
  end

  hlt_ram #(
    .WIDTH (hlt_pkg::ADDR_W),
    .WORDS (CPUS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cpu_idx),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (data)
  );

endmodule
